[hdl/t2tag_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2tag_pkg
// Shared constants and types for the Type 2 tag command responder: command
// codes, answer codes, field widths, configuration indexes and the page memory write request.
// ----------------------------------------------------------------------------
package t2tag_pkg;

    // Field widths fixed by the frame format.
    localparam int PAGE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int FLEN_W   = 7;
    localparam int BCNT_W   = 3;
    localparam int CFGIDX_W = 3;
    localparam int CFGDAT_W = 64;
    localparam int UID_W    = 56;

    // Defaults for the top-level parameters.
    localparam int DEF_PAGES     = 135;
    localparam int DEF_MAX_BURST = 64;

    // Reader command codes.
    localparam logic [7:0] CMD_READ    = 8'h30;
    localparam logic [7:0] CMD_WRITE   = 8'hA2;
    localparam logic [7:0] CMD_VERSION = 8'h60;
    localparam logic [7:0] CMD_SIG     = 8'h3C;
    localparam logic [7:0] CMD_AUTH    = 8'h1B;
    localparam logic [7:0] CMD_FAST    = 8'h3A;

    // Four-bit answer codes.
    localparam logic [3:0] CODE_ACK  = 4'hA;
    localparam logic [3:0] CODE_NACK = 4'h0;

    // Configuration register indexes.
    localparam logic [CFGIDX_W-1:0] CFG_UID   = 3'd0;
    localparam logic [CFGIDX_W-1:0] CFG_SIG_0 = 3'd1;
    localparam logic [CFGIDX_W-1:0] CFG_SIG_1 = 3'd2;
    localparam logic [CFGIDX_W-1:0] CFG_SIG_2 = 3'd3;
    localparam logic [CFGIDX_W-1:0] CFG_SIG_3 = 3'd4;

    // Write port request into the page memory.
    typedef struct packed {
        logic              en;     // write one page
        logic              clear;  // mark every page as erased
        logic [PAGE_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } t2tag_wr_t;

endpackage

[hdl/type2_tag_command_responder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// type2_tag_command_responder
// Type 2 tag emulation: answers reader commands against the tag page memory
// and keeps a flag that records WRITE commands since the last format.
// ----------------------------------------------------------------------------
// A command is taken when s_ready is high, and the block then stays busy
// until the command's last result has been loaded into the output register;
// the next command can be taken while that last result still waits on
// m_ready. Page data comes through a single memory read port with registered
// data, so every page of a READ or FAST_READ passes a read state, then an
// output state: a READ gives four pages, a FAST_READ s_page to s_end_page. A
// WRITE reads its page back before the write (not when the page is fully
// locked or the frame is refused); a format erases every page at once, then
// writes each preset page. GET_VERSION, READ_SIG and PWD_AUTH give one
// word a cycle unless the output stalls. Unknown commands give no result.
// ----------------------------------------------------------------------------
module type2_tag_command_responder
    import t2tag_pkg::*;
#(
    parameter int PAGES     = DEF_PAGES,
    parameter int MAX_BURST = DEF_MAX_BURST
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Command channel.
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [7:0]          s_command,
    input  logic [PAGE_W-1:0]   s_page,
    input  logic [PAGE_W-1:0]   s_end_page,
    input  logic [WORD_W-1:0]   s_write_data,
    input  logic [FLEN_W-1:0]   s_frame_len,
    // Result channel.
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_is_ack,
    output logic [WORD_W-1:0]   m_word,
    output logic [BCNT_W-1:0]   m_byte_count,
    output logic                m_last,
    output logic                m_modified,
    // Configuration write channel.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFGIDX_W-1:0] cfg_index,
    input  logic [CFGDAT_W-1:0] cfg_wdata
);

    localparam int REM_W = $clog2(MAX_BURST + 1);

    // Fixed page layout.
    localparam logic [PAGE_W-1:0] UID_PAGES    = 8'd2;   // pages fully locked
    localparam logic [PAGE_W-1:0] PARTIAL_PAGE = 8'd2;   // first two bytes locked
    localparam logic [PAGE_W-1:0] LOCKED_PAGE  = 8'd133;
    localparam logic [PAGE_W-1:0] LAST_PAGE    = PAGE_W'(PAGES - 1);
    localparam logic [2:0]        FMT_STEPS    = 3'd6;

    localparam logic [WORD_W-1:0] VERSION_0 = 32'h0204_0400;
    localparam logic [WORD_W-1:0] VERSION_1 = 32'h0311_0001;
    localparam logic [WORD_W-1:0] AUTH_WORD = 32'h0000_8080;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FMT   = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_PAGE  = 3'd3;
    localparam logic [2:0] S_WRRD  = 3'd4;
    localparam logic [2:0] S_WR    = 3'd5;
    localparam logic [2:0] S_CODE  = 3'd6;
    localparam logic [2:0] S_CONST = 3'd7;

    // Kinds of constant answer.
    localparam logic [1:0] K_VER  = 2'd0;
    localparam logic [1:0] K_SIG  = 2'd1;
    localparam logic [1:0] K_AUTH = 2'd2;

    logic [2:0]          state_reg,  state_next;
    logic [PAGE_W-1:0]   addr_reg,   addr_next;
    logic [REM_W-1:0]    rem_reg,    rem_next;
    logic [2:0]          idx_reg,    idx_next;
    logic [1:0]          kind_reg,   kind_next;
    logic [3:0]          code_reg,   code_next;
    logic [WORD_W-1:0]   data_reg,   data_next;
    logic                dirty_reg,  dirty_next;
    logic [UID_W-1:0]    uid_reg;
    logic [CFGDAT_W-1:0] sig_reg [4];

    logic                m_valid_reg,      m_valid_next;
    logic                m_is_ack_reg,     m_is_ack_next;
    logic [WORD_W-1:0]   m_word_reg,       m_word_next;
    logic [BCNT_W-1:0]   m_byte_count_reg, m_byte_count_next;
    logic                m_last_reg,       m_last_next;
    logic                m_modified_reg,   m_modified_next;

    t2tag_wr_t           wr;
    logic                rd_en;
    logic [WORD_W-1:0]   rd_data;
    logic                slot_free;
    logic                accept;
    logic [PAGE_W-1:0]   addr_inc;
    logic                rem_last;
    logic [PAGE_W:0]     span;
    logic                fast_bad;
    logic                page_bad;
    logic [CFGDAT_W-1:0] sig_sel;
    logic [WORD_W-1:0]   const_word;
    logic [BCNT_W-1:0]   const_bcnt;

    // Preset page numbers written by a format.
    function automatic logic [PAGE_W-1:0] fmt_page(input logic [2:0] idx);
        logic [PAGE_W-1:0] p;
        unique case (idx)
            3'd0:    p = 8'd0;
            3'd1:    p = 8'd1;
            3'd2:    p = 8'd2;
            3'd3:    p = 8'd3;
            3'd4:    p = 8'd4;
            default: p = 8'd131;
        endcase
        return p;
    endfunction

    // Preset page contents: identifier with check bytes, capability
    // container, empty message TLV and the configuration page defaults.
    function automatic logic [WORD_W-1:0] fmt_word(input logic [2:0] idx,
                                                   input logic [UID_W-1:0] u);
        logic [7:0]        bcc0;
        logic [7:0]        bcc1;
        logic [WORD_W-1:0] w;
        bcc0 = 8'h88 ^ u[7:0] ^ u[15:8] ^ u[23:16];
        bcc1 = u[31:24] ^ u[39:32] ^ u[47:40] ^ u[55:48];
        unique case (idx)
            3'd0:    w = {bcc0, u[23:0]};
            3'd1:    w = u[55:24];
            3'd2:    w = {16'h0000, 8'h48, bcc1};
            3'd3:    w = 32'h003E_10E1;
            3'd4:    w = 32'h00FE_0003;
            default: w = 32'hFF00_0004;
        endcase
        return w;
    endfunction

    t2tag_page_mem #(
        .PAGES (PAGES)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // Handshakes.
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;

    // Shared page stepper: wrapping increment and burst countdown.
    assign addr_inc = (addr_reg == LAST_PAGE) ? '0 : addr_reg + 1'b1;
    assign rem_last = (rem_reg == REM_W'(1));

    // Range checks on the incoming frame.
    assign page_bad = ({1'b0, s_page} >= (PAGE_W + 1)'(PAGES));
    assign span     = {1'b0, s_end_page} - {1'b0, s_page};
    assign fast_bad = (s_page > s_end_page)
                   || ({1'b0, s_end_page} >= (PAGE_W + 1)'(PAGES))
                   || (span >= (PAGE_W + 1)'(MAX_BURST));

    // Constant answers: version words, signature words or the auth reply.
    assign sig_sel = sig_reg[idx_reg[2:1]];
    always_comb begin
        const_word = AUTH_WORD;
        const_bcnt = 3'd2;
        unique case (kind_reg)
            K_VER: begin
                const_word = idx_reg[0] ? VERSION_1 : VERSION_0;
                const_bcnt = 3'd4;
            end
            K_SIG: begin
                const_word = idx_reg[0] ? sig_sel[63:32] : sig_sel[31:0];
                const_bcnt = 3'd4;
            end
            default: begin
                const_word = AUTH_WORD;
                const_bcnt = 3'd2;
            end
        endcase
    end

    // Command sequencer.
    always_comb begin
        state_next        = state_reg;
        addr_next         = addr_reg;
        rem_next          = rem_reg;
        idx_next          = idx_reg;
        kind_next         = kind_reg;
        code_next         = code_reg;
        data_next         = data_reg;
        dirty_next        = dirty_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_is_ack_next     = m_is_ack_reg;
        m_word_next       = m_word_reg;
        m_byte_count_next = m_byte_count_reg;
        m_last_next       = m_last_reg;
        m_modified_next   = m_modified_reg;
        wr                = '0;
        rd_en             = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    addr_next = s_page;
                    data_next = s_write_data;
                    idx_next  = '0;
                    if (s_op) begin
                        // Format: erase every page now, presets follow.
                        wr.clear   = 1'b1;
                        dirty_next = 1'b0;
                        state_next = S_FMT;
                    end else begin
                        unique case (s_command)
                            CMD_READ: begin
                                if (page_bad) begin
                                    code_next  = CODE_NACK;
                                    state_next = S_CODE;
                                end else begin
                                    rem_next   = REM_W'(4);
                                    state_next = S_RD;
                                end
                            end
                            CMD_WRITE: begin
                                dirty_next = 1'b1;
                                code_next  = CODE_ACK;
                                if (s_frame_len != FLEN_W'(6) || page_bad) begin
                                    code_next  = CODE_NACK;
                                    state_next = S_CODE;
                                end else if (s_page < UID_PAGES || s_page == LOCKED_PAGE) begin
                                    state_next = S_CODE;
                                end else begin
                                    state_next = S_WRRD;
                                end
                            end
                            CMD_VERSION: begin
                                kind_next  = K_VER;
                                rem_next   = REM_W'(2);
                                state_next = S_CONST;
                            end
                            CMD_SIG: begin
                                kind_next  = K_SIG;
                                rem_next   = REM_W'(8);
                                state_next = S_CONST;
                            end
                            CMD_AUTH: begin
                                kind_next  = K_AUTH;
                                rem_next   = REM_W'(1);
                                state_next = S_CONST;
                            end
                            CMD_FAST: begin
                                if (fast_bad) begin
                                    code_next  = CODE_NACK;
                                    state_next = S_CODE;
                                end else begin
                                    rem_next   = REM_W'(span + 1'b1);
                                    state_next = S_RD;
                                end
                            end
                            default: begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end

            S_FMT: begin
                wr.en    = 1'b1;
                wr.addr  = fmt_page(idx_reg);
                wr.data  = fmt_word(idx_reg, uid_reg);
                idx_next = idx_reg + 1'b1;
                if (idx_reg == FMT_STEPS - 1'b1) begin
                    state_next = S_IDLE;
                end
            end

            S_RD: begin
                rd_en      = 1'b1;
                state_next = S_PAGE;
            end

            S_PAGE: begin
                if (slot_free) begin
                    m_valid_next      = 1'b1;
                    m_is_ack_next     = 1'b0;
                    m_word_next       = rd_data;
                    m_byte_count_next = 3'd4;
                    m_last_next       = rem_last;
                    m_modified_next   = dirty_reg;
                    addr_next         = addr_inc;
                    rem_next          = rem_reg - 1'b1;
                    state_next        = rem_last ? S_IDLE : S_RD;
                end
            end

            S_WRRD: begin
                rd_en      = 1'b1;
                state_next = S_WR;
            end

            S_WR: begin
                // The first two bytes of the partial page stay locked.
                wr.en      = 1'b1;
                wr.addr    = addr_reg;
                wr.data    = (addr_reg == PARTIAL_PAGE) ?
                             {data_reg[31:16], rd_data[15:0]} : data_reg;
                state_next = S_CODE;
            end

            S_CODE: begin
                if (slot_free) begin
                    m_valid_next      = 1'b1;
                    m_is_ack_next     = 1'b1;
                    m_word_next       = {28'h0, code_reg};
                    m_byte_count_next = 3'd1;
                    m_last_next       = 1'b1;
                    m_modified_next   = dirty_reg;
                    state_next        = S_IDLE;
                end
            end

            S_CONST: begin
                if (slot_free) begin
                    m_valid_next      = 1'b1;
                    m_is_ack_next     = 1'b0;
                    m_word_next       = const_word;
                    m_byte_count_next = const_bcnt;
                    m_last_next       = rem_last;
                    m_modified_next   = dirty_reg;
                    idx_next          = idx_reg + 1'b1;
                    rem_next          = rem_reg - 1'b1;
                    state_next        = rem_last ? S_IDLE : S_CONST;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            dirty_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dirty_reg   <= dirty_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge aclk) begin
        addr_reg         <= addr_next;
        rem_reg          <= rem_next;
        idx_reg          <= idx_next;
        kind_reg         <= kind_next;
        code_reg         <= code_next;
        data_reg         <= data_next;
        m_is_ack_reg     <= m_is_ack_next;
        m_word_reg       <= m_word_next;
        m_byte_count_reg <= m_byte_count_next;
        m_last_reg       <= m_last_next;
        m_modified_reg   <= m_modified_next;
    end

    // Configuration registers; a transfer to an unused index is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uid_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                sig_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_UID:   uid_reg    <= cfg_wdata[UID_W-1:0];
                CFG_SIG_0: sig_reg[0] <= cfg_wdata;
                CFG_SIG_1: sig_reg[1] <= cfg_wdata;
                CFG_SIG_2: sig_reg[2] <= cfg_wdata;
                CFG_SIG_3: sig_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_is_ack     = m_is_ack_reg;
    assign m_word       = m_word_reg;
    assign m_byte_count = m_byte_count_reg;
    assign m_last       = m_last_reg;
    assign m_modified   = m_modified_reg;

endmodule

[hdl/t2tag_page_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2tag_page_mem
// Tag page store: one write port, one read port with registered data. A valid
// bit per page makes an erased page read as zero, so a format clears the
// whole store at once.
// ----------------------------------------------------------------------------
module t2tag_page_mem
    import t2tag_pkg::*;
#(
    parameter int PAGES = DEF_PAGES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  t2tag_wr_t         wr,
    input  logic              rd_en,
    input  logic [PAGE_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    localparam int AW = $clog2(PAGES);

    logic [WORD_W-1:0] mem [PAGES];
    logic [PAGES-1:0]  valid_reg;
    logic [WORD_W-1:0] rdata_reg;
    logic              rvalid_reg;

    // Page array write and registered read.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    // Valid bits: cleared by reset or a format, set by each page write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (wr.clear) begin
                valid_reg <= '0;
            end else if (wr.en) begin
                valid_reg[wr.addr[AW-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                rvalid_reg <= valid_reg[rd_addr[AW-1:0]];
            end
        end
    end

    // An erased page reads as zero.
    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

[hdl/t2tag_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2tag_checker
// Port-level checks for the tag command responder, attached to the top level
// by the bind statement at the end of this file.
// ----------------------------------------------------------------------------
module t2tag_checker
    import t2tag_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                s_op,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_is_ack,
    input logic [WORD_W-1:0]   m_word,
    input logic [BCNT_W-1:0]   m_byte_count,
    input logic                m_last
);

    // A stalled result holds its word until the transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // An answer code is a single-byte, final result with a four-bit code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_ack |-> m_byte_count == 3'd1 && m_last && m_word[31:4] == '0)
        else $error("malformed answer code result");

    // Data results carry two or four bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_ack |-> m_byte_count == 3'd4 || m_byte_count == 3'd2)
        else $error("data result with bad byte count");

    // A format keeps the command channel busy for the preset writes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op |=> !s_ready)
        else $error("command taken during format");

endmodule

bind type2_tag_command_responder t2tag_checker u_t2tag_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_op         (s_op),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_is_ack     (m_is_ack),
    .m_word       (m_word),
    .m_byte_count (m_byte_count),
    .m_last       (m_last)
);
